// ----- design/kclpd_pkg.sv -----
// ----------------------------------------------------------------------------
// kclpd_pkg
// Shared types and constants of the key click / long-press detector.
// ----------------------------------------------------------------------------
package kclpd_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TickW    = 16;

  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_LEVEL = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DOUBLE_CLICK = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT       = 3'd4;

  // Register reset values
  localparam logic             RstActiveLevel = 1'b0;
  localparam logic [TickW-1:0] RstDebounce    = 16'd1;
  localparam logic [TickW-1:0] RstLongPress   = 16'd50;
  localparam logic [TickW-1:0] RstDoubleClick = 16'd15;
  localparam logic [TickW-1:0] RstRepeat      = 16'd5;

  // Stream word widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;

  // Key state machine, one-hot
  typedef enum logic [4:0] {
    ST_RELEASED = 5'b00001,
    ST_DEBOUNCE = 5'b00010,
    ST_PRESSED  = 5'b00100,
    ST_LONG     = 5'b01000,
    ST_WAIT2    = 5'b10000
  } key_state_e;

  // Event codes
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_PRESS  = 3'd1,
    EV_SHORT  = 3'd2,
    EV_LONG   = 3'd3,
    EV_REPEAT = 3'd4,
    EV_DOUBLE = 3'd5
  } key_event_e;

  // One result word
  typedef struct packed {
    logic       is_long_pressed;
    logic       is_pressed;
    key_event_e event_code;
  } key_result_t;

endpackage

// ----- design/key_click_long_press_detector_unit.sv -----
// ----------------------------------------------------------------------------
// key_click_long_press_detector_unit
// Result words are registered, valid in the cycle after their input is taken.
// Throughput: one word per cycle while the output side takes words; input
// ready is held low only while the output register holds an untaken word.
// Reset (rst_ni, async, active low): state machine to released, counters to
// zero, output register empty, configuration registers to their defaults.
// ----------------------------------------------------------------------------
// Debounces a key pin sampled once per scan tick and reports press, short
// press, long press, long-press repeat and double-click events, one result
// word per scan tick.
// ----------------------------------------------------------------------------
module key_click_long_press_detector_unit #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [kclpd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [kclpd_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream: [0] raw_level, [7:1] zero
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [kclpd_pkg::InDataW-1:0] s_axis_tdata,
  // output stream: [2:0] event_code, [3] is_pressed, [4] is_long_pressed,
  // [7:5] zero
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [kclpd_pkg::OutDataW-1:0] m_axis_tdata
);
  import kclpd_pkg::*;

  localparam int unsigned CmpW = (COUNTER_BITS > TickW) ? COUNTER_BITS : TickW;
  localparam logic [COUNTER_BITS-1:0] CntMax = {COUNTER_BITS{1'b1}};

  // Configuration registers
  logic             active_level_q;
  logic [TickW-1:0] debounce_q, long_press_q, double_click_q, repeat_q;

  // Detector state
  key_state_e              state_q, state_d;
  logic [COUNTER_BITS-1:0] press_q, press_d;
  logic [COUNTER_BITS-1:0] release_q, release_d;
  logic [COUNTER_BITS-1:0] repeat_cnt_q, repeat_cnt_d;
  logic [1:0]              tally_q, tally_d;
  logic                    long_fired_q, long_fired_d;

  // Output register
  logic        out_valid_q;
  key_result_t out_q, out_d;

  logic                    accept;
  logic                    down;
  logic [COUNTER_BITS-1:0] press_inc, release_inc, repeat_inc;
  key_event_e              ev;

  // Write configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_level_q <= RstActiveLevel;
      debounce_q     <= RstDebounce;
      long_press_q   <= RstLongPress;
      double_click_q <= RstDoubleClick;
      repeat_q       <= RstRepeat;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTIVE_LEVEL: active_level_q <= cfg_data_i[0];
        CFG_DEBOUNCE:     debounce_q     <= cfg_data_i[TickW-1:0];
        CFG_LONG_PRESS:   long_press_q   <= cfg_data_i[TickW-1:0];
        CFG_DOUBLE_CLICK: double_click_q <= cfg_data_i[TickW-1:0];
        CFG_REPEAT:       repeat_q       <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  // Take a word whenever the output slot is free or being emptied
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign down = (s_axis_tdata[0] == active_level_q);

  // Saturating increments
  assign press_inc   = (press_q == CntMax) ? CntMax : press_q + 1'b1;
  assign release_inc = (release_q == CntMax) ? CntMax : release_q + 1'b1;
  assign repeat_inc  = (repeat_cnt_q == CntMax) ? CntMax : repeat_cnt_q + 1'b1;

  // Advance the key state machine by one scan tick
  always_comb begin
    state_d      = state_q;
    press_d      = press_q;
    release_d    = release_q;
    repeat_cnt_d = repeat_cnt_q;
    tally_d      = tally_q;
    long_fired_d = long_fired_q;
    ev           = EV_NONE;

    unique case (state_q)
      ST_DEBOUNCE: begin
        if (down) begin
          press_d = press_inc;
          if (CmpW'(press_inc) >= CmpW'(debounce_q)) begin
            state_d = ST_PRESSED;
            ev      = EV_PRESS;
            if (tally_q != 2'd3) tally_d = tally_q + 2'd1;
            press_d = '0;
          end
        end else begin
          state_d = ST_RELEASED;
        end
      end

      ST_PRESSED: begin
        if (!down) begin
          state_d   = ST_DEBOUNCE;
          release_d = '0;
          if (CmpW'(press_q) < CmpW'(long_press_q)) begin
            priority if (tally_q == 2'd1) begin
              state_d = ST_WAIT2;
            end else if (tally_q >= 2'd2) begin
              ev      = EV_DOUBLE;
              tally_d = '0;
              state_d = ST_RELEASED;
            end
          end else begin
            ev      = EV_SHORT;
            tally_d = '0;
          end
          press_d      = '0;
          long_fired_d = 1'b0;
        end else begin
          press_d = press_inc;
          if (CmpW'(press_inc) >= CmpW'(long_press_q) && !long_fired_q) begin
            ev           = EV_LONG;
            long_fired_d = 1'b1;
            state_d      = ST_LONG;
            repeat_cnt_d = '0;
            tally_d      = '0;
          end
        end
      end

      ST_LONG: begin
        if (!down) begin
          state_d      = ST_DEBOUNCE;
          long_fired_d = 1'b0;
          press_d      = '0;
        end else begin
          repeat_cnt_d = repeat_inc;
          if (repeat_q != '0 && CmpW'(repeat_inc) >= CmpW'(repeat_q)) begin
            ev           = EV_REPEAT;
            repeat_cnt_d = '0;
          end
        end
      end

      ST_WAIT2: begin
        if (down) begin
          state_d   = ST_DEBOUNCE;
          press_d   = '0;
          release_d = '0;
        end else begin
          release_d = release_inc;
          if (CmpW'(release_inc) >= CmpW'(double_click_q)) begin
            if (tally_q == 2'd1) ev = EV_SHORT;
            state_d = ST_RELEASED;
            tally_d = '0;
          end
        end
      end

      default: begin
        if (down) begin
          state_d      = ST_DEBOUNCE;
          press_d      = '0;
          long_fired_d = 1'b0;
          repeat_cnt_d = '0;
        end else begin
          state_d = ST_RELEASED;
        end
        release_d = '0;
      end
    endcase

    out_d.event_code      = ev;
    out_d.is_pressed      = (state_d == ST_PRESSED) || (state_d == ST_LONG);
    out_d.is_long_pressed = (state_d == ST_LONG);
  end

  // Update state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RELEASED;
      press_q      <= '0;
      release_q    <= '0;
      repeat_cnt_q <= '0;
      tally_q      <= '0;
      long_fired_q <= 1'b0;
    end else if (accept) begin
      state_q      <= state_d;
      press_q      <= press_d;
      release_q    <= release_d;
      repeat_cnt_q <= repeat_cnt_d;
      tally_q      <= tally_d;
      long_fired_q <= long_fired_d;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_q);

  // Checks
  a_long_flag_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_fired_q |-> state_q == ST_LONG)
    else $error("long_fired set outside long-pressed state");

  a_long_implies_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.is_long_pressed) |-> out_q.is_pressed)
    else $error("long-pressed flag without pressed flag");

  a_press_event_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.event_code == EV_PRESS) |->
      (out_q.is_pressed && !out_q.is_long_pressed))
    else $error("press event without pressed state");

  a_long_event_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.event_code == EV_LONG || out_q.event_code == EV_REPEAT))
      |-> out_q.is_long_pressed)
    else $error("long or repeat event outside long-pressed state");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output register");

endmodule

// ----- test/key_click_long_press_detector_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_click_long_press_detector_unit_tb
// Self-checking bench for the key click / long-press detector.
// A short table of directed scan ticks and register writes comes first. Random
// press and release gestures follow under several register settings, then a
// long hold with back-to-back words that runs through repeat events. Both
// stream sides idle at random. Every result word is checked against a local
// model of the key state machine, or against a typed-in result in the table.
// ----------------------------------------------------------------------------
module key_click_long_press_detector_unit_tb;
  import kclpd_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = CFG_REPEAT + 1'b1;
  localparam logic [CfgIdxW-1:0] CfgIdxTop   = '1;
  localparam int unsigned        ResW        = $bits(key_result_t);
  localparam int                 PlanLen     = 36;

  typedef logic [TickW-1:0] tick_t;
  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  // One directed step: a scan tick (optionally with a typed-in result) or a
  // register write
  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic                 level;
    bit                   typed;
    key_event_e           ev;
    logic                 pr;
    logic                 lp;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;   // [0] raw_level, [7:1] zero
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [2:0] event_code, [3] is_pressed, [4] is_long_pressed, [7:5] zero
  logic [OutDataW-1:0]  m_axis_tdata;

  // Register copy used by the key model
  logic  cfg_active   = RstActiveLevel;
  tick_t cfg_debounce = RstDebounce;
  tick_t cfg_long     = RstLongPress;
  tick_t cfg_double   = RstDoubleClick;
  tick_t cfg_repeat   = RstRepeat;

  // Key model state
  key_state_e kp_state  = ST_RELEASED;
  tick_t      hold_cnt  = '0;
  tick_t      gap_cnt   = '0;
  tick_t      rep_cnt   = '0;
  logic [1:0] clicks    = '0;
  logic       long_done = 1'b0;

  key_result_t pending_results[$];
  int          mismatches = 0;
  int          sent_items = 0;
  int          in_stretch = 0;
  int          out_stretch = 0;
  bit          hurry = 1'b0;

  row_t plan [PlanLen] = '{
    // default registers, pin low is pressed: click, click = double click
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 1'b1, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 1'b1, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 1'b1, EV_PRESS,  1'b1, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 1'b1, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 1'b1, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 1'b1, EV_PRESS,  1'b1, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 1'b1, EV_DOUBLE, 1'b0, 1'b0},
    // zero double-click window: single click times out at once
    '{ROW_CFG,  CFG_DOUBLE_CLICK, 16'h0000, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 1'b0, EV_NONE,   1'b0, 1'b0},
    // pin high is pressed, zero debounce and long press, repeat every tick
    '{ROW_CFG,  CFG_ACTIVE_LEVEL, 16'hFFFF, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_CFG,  CFG_DEBOUNCE,     16'h0000, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_CFG,  CFG_LONG_PRESS,   16'h0000, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_CFG,  CFG_REPEAT,       16'h0001, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_CFG,  CfgIdxSpare,      16'hFFFF, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 1'b1, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 1'b1, EV_PRESS,  1'b1, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 1'b1, EV_LONG,   1'b1, 1'b1},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 1'b1, EV_REPEAT, 1'b1, 1'b1},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 1'b1, EV_REPEAT, 1'b1, 1'b1},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 1'b1, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 1'b1, EV_NONE,   1'b0, 1'b0},
    // release right after acceptance with zero long press: short press
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 1'b1, EV_SHORT,  1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    // all thresholds at their maximum, repeat off
    '{ROW_CFG,  CFG_DEBOUNCE,     16'hFFFF, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_CFG,  CFG_LONG_PRESS,   16'hFFFF, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_CFG,  CFG_DOUBLE_CLICK, 16'hFFFF, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_CFG,  CFG_REPEAT,       16'h0000, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_CFG,  CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0},
    '{ROW_TICK, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 1'b0, EV_NONE,   1'b0, 1'b0}
  };

  key_click_long_press_detector_unit #(
    .COUNTER_BITS(TickW)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Upper bound on the run
  initial begin
    #(20_000_000);
    $display("Verification failed");
    $finish;
  end

  function automatic tick_t sat_inc(input tick_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Advance the key model by one scan tick and return the result word
  function automatic key_result_t advance_key(input logic level);
    key_result_t r;
    logic        down;
    key_event_e  ev;
    down = (level == cfg_active);
    ev   = EV_NONE;
    case (kp_state)
      ST_DEBOUNCE: begin
        if (down) begin
          hold_cnt = sat_inc(hold_cnt);
          if (hold_cnt >= cfg_debounce) begin
            kp_state = ST_PRESSED;
            ev       = EV_PRESS;
            if (clicks < 2'd3) clicks++;
            hold_cnt = '0;
          end
        end else begin
          kp_state = ST_RELEASED;
        end
      end
      ST_PRESSED: begin
        if (!down) begin
          kp_state = ST_DEBOUNCE;
          gap_cnt  = '0;
          if (hold_cnt < cfg_long) begin
            if (clicks == 2'd1) begin
              kp_state = ST_WAIT2;
            end else if (clicks >= 2'd2) begin
              ev       = EV_DOUBLE;
              clicks   = '0;
              kp_state = ST_RELEASED;
            end
          end else begin
            ev     = EV_SHORT;
            clicks = '0;
          end
          hold_cnt  = '0;
          long_done = 1'b0;
        end else begin
          hold_cnt = sat_inc(hold_cnt);
          if (hold_cnt >= cfg_long && !long_done) begin
            ev        = EV_LONG;
            long_done = 1'b1;
            kp_state  = ST_LONG;
            rep_cnt   = '0;
            clicks    = '0;
          end
        end
      end
      ST_LONG: begin
        if (!down) begin
          kp_state  = ST_DEBOUNCE;
          long_done = 1'b0;
          hold_cnt  = '0;
        end else begin
          rep_cnt = sat_inc(rep_cnt);
          if (cfg_repeat != '0 && rep_cnt >= cfg_repeat) begin
            ev      = EV_REPEAT;
            rep_cnt = '0;
          end
        end
      end
      ST_WAIT2: begin
        if (down) begin
          kp_state = ST_DEBOUNCE;
          hold_cnt = '0;
          gap_cnt  = '0;
        end else begin
          gap_cnt = sat_inc(gap_cnt);
          if (gap_cnt >= cfg_double) begin
            if (clicks == 2'd1) ev = EV_SHORT;
            kp_state = ST_RELEASED;
            clicks   = '0;
          end
        end
      end
      default: begin
        if (down) begin
          kp_state  = ST_DEBOUNCE;
          hold_cnt  = '0;
          long_done = 1'b0;
          rep_cnt   = '0;
        end else begin
          kp_state = ST_RELEASED;
        end
        gap_cnt = '0;
      end
    endcase
    r.event_code      = ev;
    r.is_pressed      = (kp_state == ST_PRESSED) || (kp_state == ST_LONG);
    r.is_long_pressed = (kp_state == ST_LONG);
    return r;
  endfunction

  // Idle cycles before the next word, with runs of back-to-back words
  function automatic int pick_idle(inout int stretch);
    if (hurry) return 0;
    if (stretch > 0) begin
      stretch--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      stretch = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Duration around a threshold, kept short for large thresholds
  function automatic int span(input int thr);
    if (thr > 40) return $urandom_range(0, 40);
    return $urandom_range(0, thr + 3);
  endfunction

  task automatic flag(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Send one scan tick and queue the result it must produce
  task automatic send_tick(input logic level, input bit typed = 1'b0,
                           input key_result_t want = '0);
    int          idle;
    key_result_t predicted;
    idle = pick_idle(in_stretch);
    @(negedge clk_i);
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-1){1'b0}}, level};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_key(level);
    pending_results.push_back(typed ? want : predicted);
    sent_items++;
  endtask

  // Hold the input and wait until every queued result word has come back
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_ACTIVE_LEVEL: cfg_active   = data[0];
      CFG_DEBOUNCE:     cfg_debounce = data;
      CFG_LONG_PRESS:   cfg_long     = data;
      CFG_DOUBLE_CLICK: cfg_double   = data;
      CFG_REPEAT:       cfg_repeat   = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drain, then write every register plus one unused index
  task automatic program_phase(input logic [CfgDataW-1:0] act, input tick_t deb,
                               input tick_t lng, input tick_t dbl, input tick_t rep);
    settle();
    set_reg(CFG_ACTIVE_LEVEL, act);
    set_reg(CFG_DEBOUNCE, deb);
    set_reg(CFG_LONG_PRESS, lng);
    set_reg(CFG_DOUBLE_CLICK, dbl);
    set_reg(CFG_REPEAT, rep);
    set_reg(CfgIdxW'(CfgIdxSpare + $urandom_range(0, CfgIdxTop - CfgIdxSpare)),
            CfgDataW'($urandom_range(0, 65535)));
  endtask

  // Random presses and releases sized around the thresholds, with bounce
  // and some plain noise
  task automatic play_gestures(input int count);
    int   target;
    int   hold;
    int   gap;
    logic dn;
    target = sent_items + count;
    while (sent_items < target) begin
      dn = cfg_active;
      if ($urandom_range(0, 9) < 2) begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
      end else begin
        hold = span(int'(cfg_debounce) + 1) +
               span(int'(cfg_long) + 3 * int'(cfg_repeat)) + 1;
        repeat (hold) send_tick(($urandom_range(0, 30) == 0) ? ~dn : dn);
        gap = span(int'(cfg_double) + 1) + 1;
        repeat (gap) send_tick(~dn);
      end
      if ($urandom_range(0, 60) == 0) settle();
    end
  endtask

  // Result side: random stalls per word
  initial begin
    int idle;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      idle = pick_idle(out_stretch);
      @(negedge clk_i);
      if (idle > 0) begin
        m_axis_tready <= 1'b0;
        repeat (idle) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    key_result_t got;
    key_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = key_result_t'(m_axis_tdata[ResW-1:0]);
      if (pending_results.size() == 0) begin
        flag($sformatf("result word 0x%02h with nothing pending", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.event_code != want.event_code)
          flag($sformatf("event_code got %0d want %0d", got.event_code, want.event_code));
        if (got.is_pressed != want.is_pressed)
          flag($sformatf("is_pressed got %0b want %0b", got.is_pressed, want.is_pressed));
        if (got.is_long_pressed != want.is_long_pressed)
          flag($sformatf("is_long_pressed got %0b want %0b",
                         got.is_long_pressed, want.is_long_pressed));
        if (m_axis_tdata[OutDataW-1:ResW] != '0)
          flag($sformatf("padding bits got 0x%0h", m_axis_tdata[OutDataW-1:ResW]));
      end
    end
  end

  // Stimulus
  initial begin
    logic pressed;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ACTIVE_LEVEL;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        set_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(plan[i].level, plan[i].typed,
                  '{is_long_pressed: plan[i].lp, is_pressed: plan[i].pr,
                    event_code: plan[i].ev});
      end
    end

    // Random gestures: all-zero and all-maximum settings, then mixed ones
    program_phase(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    play_gestures(200);
    program_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    play_gestures(150);
    repeat (6) begin
      program_phase(CfgDataW'($urandom_range(0, 65535)), TickW'($urandom_range(0, 3)),
                    TickW'($urandom_range(0, 10)), TickW'($urandom_range(0, 6)),
                    TickW'($urandom_range(0, 3)));
      play_gestures(200);
    end

    // Hold a long press with back-to-back words and a short repeat interval,
    // then let go
    program_phase(CfgDataW'($urandom_range(0, 1)), 16'h0000, 16'h0000, 16'h0003,
                  16'h0002);
    hurry   = 1'b1;
    pressed = cfg_active;
    repeat (40) send_tick(pressed);
    repeat (2) send_tick(~pressed);
    hurry = 1'b0;

    // Drain and finish
    settle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
